>>> rtl/core/glc_pkg.sv
// ---------------------------------------------------------------------------
// glc_pkg - shared types and constants of the glyph cache tag store
// Beat layouts, slot entry layout and sizing constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package glc_pkg;

	localparam int SLOTS      = 32;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int SLOT_BYTES = 256;
	// ceil(bits / 8) > SLOT_BYTES  <=>  bits > SLOT_BYTES * 8
	localparam int SIZE_LIMIT = SLOT_BYTES * 8;
	localparam int AREA_W     = 16;
	localparam int BITS_W     = AREA_W + 4;
	localparam int AGE_W      = 32;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [1:0]        font_id;
		logic [20:0]       code_point;
		logic [7:0]        glyph_width;
		logic [7:0]        glyph_height;
		logic signed [7:0] offset_x;
		logic signed [7:0] offset_y;
		logic [7:0]        advance;
		logic [3:0]        bits_per_pixel;
	} glc_req_t;

	typedef struct packed {
		logic              hit;
		logic              stored;
		logic [4:0]        slot_index;
		logic [7:0]        out_width;
		logic [7:0]        out_height;
		logic signed [7:0] out_offset_x;
		logic signed [7:0] out_offset_y;
		logic [7:0]        out_advance;
		logic [3:0]        out_bpp;
	} glc_rsp_t;

	typedef struct packed {
		logic [7:0]        width;
		logic [7:0]        height;
		logic signed [7:0] offset_x;
		logic signed [7:0] offset_y;
		logic [7:0]        advance;
		logic [3:0]        bpp;
	} glc_desc_t;

	typedef struct packed {
		logic [1:0]       font;
		logic [20:0]      code_point;
		glc_desc_t        desc;
		logic [AGE_W-1:0] age;
	} glc_entry_t;

	// verdict of the slot compare unit
	typedef struct packed {
		logic hit;    // valid slot with matching key
		logic empty;  // slot not valid
		logic older;  // valid and a better victim than the best so far
	} glc_cmp_t;

endpackage

`default_nettype wire

>>> rtl/core/glc_cmp.sv
// ---------------------------------------------------------------------------
// glc_cmp - slot compare unit
// Key match for lookups, age compare for victim search; used once per slot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glc_cmp (
	input  wire logic                     slot_vld,
	input  wire glc_pkg::glc_entry_t      ent,
	input  wire logic [1:0]               font_id,
	input  wire logic [20:0]              code_point,
	input  wire logic                     first,
	input  wire logic [glc_pkg::AGE_W-1:0] best_age,
	output glc_pkg::glc_cmp_t             res
);

	always_comb begin
		res.hit   = slot_vld && (ent.font == font_id) && (ent.code_point == code_point);
		res.empty = !slot_vld;
		// a valid first slot always seeds the search; ties keep the lower index
		res.older = slot_vld && (first || (ent.age < best_age));
	end

endmodule

`default_nettype wire

>>> rtl/core/glyph_cache_lru_tag_store.sv
// ---------------------------------------------------------------------------
// glyph_cache_lru_tag_store - fully associative LRU glyph descriptor cache
// 32-slot tag store keyed by font and code point, aged by a 32-bit stamp.
// ---------------------------------------------------------------------------
// One request beat in, exactly one response beat out. A lookup scans the
// slots from 0 upward and stops at the first valid key match, stamping it
// with the next age; an insert first checks ceil(w*h*bpp/8) against the
// slot byte limit (multiplies in ST_AREA and ST_SIZE), then scans for the
// first empty slot or else the oldest one (lowest index on a tie) and
// writes it. The slot entries sit in a RAM with one read and one write
// port, read one slot per cycle. The next request can be taken in the
// cycle after the response is loaded. Only one request is in flight:
// req_stall is high from accept until the response is loaded into the
// output register, and a stalled response that still holds the output
// register keeps the block waiting in its final state. The response
// register decouples the sides, so a new request can be taken while the
// previous response is still stalled. Valid bits clear at reset, so no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module glyph_cache_lru_tag_store (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire glc_pkg::glc_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output glc_pkg::glc_rsp_t      rsp
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_AREA  = 6'b000010,
		ST_SIZE  = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_WRITE = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	localparam int SW = glc_pkg::SLOT_W;

	state_t                     state_q;
	glc_pkg::glc_req_t          req_q;
	logic [glc_pkg::AREA_W-1:0] area_q;
	logic [SW:0]                scan_q;
	logic                       eval_vld_s1;
	logic [SW-1:0]              eval_idx_s1;
	logic                       found_q;
	logic [SW-1:0]              tgt_q;
	glc_pkg::glc_entry_t        tgt_ent_q;
	logic [glc_pkg::AGE_W-1:0]  best_age_q;
	logic [glc_pkg::AGE_W-1:0]  age_q;
	logic [glc_pkg::SLOTS-1:0]  valid_q;
	logic                       rsp_valid_q;
	glc_pkg::glc_rsp_t          rsp_q;

	// slot RAM
	glc_pkg::glc_entry_t        mem [glc_pkg::SLOTS];
	glc_pkg::glc_entry_t        rd_data_q;
	logic                       mem_we;
	glc_pkg::glc_entry_t        wr_data;

	logic [glc_pkg::BITS_W-1:0] bits;
	logic [glc_pkg::AGE_W-1:0]  age_nxt;
	logic                       is_lookup;
	logic                       issue;
	logic                       last;
	logic                       rsp_free;
	glc_pkg::glc_cmp_t          cmp;

	assign is_lookup = (req_q.req_type == glc_pkg::REQ_LOOKUP);
	assign age_nxt   = age_q + glc_pkg::AGE_W'(1);
	assign last      = (eval_idx_s1 == SW'(glc_pkg::SLOTS - 1));
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign bits      = glc_pkg::BITS_W'(area_q) * glc_pkg::BITS_W'(req_q.bits_per_pixel);

	glc_cmp u_cmp (
		.slot_vld   (valid_q[eval_idx_s1]),
		.ent        (rd_data_q),
		.font_id    (req_q.font_id),
		.code_point (req_q.code_point),
		.first      (eval_idx_s1 == '0),
		.best_age   (best_age_q),
		.res        (cmp)
	);

	// a stop decision in the eval stage cancels the read issued alongside it
	always_comb begin
		issue = (state_q == ST_SCAN) && (scan_q < (SW + 1)'(glc_pkg::SLOTS));
		if (eval_vld_s1 && (is_lookup ? cmp.hit : cmp.empty)) begin
			issue = 1'b0;
		end
	end

	always_comb begin
		mem_we  = (state_q == ST_WRITE);
		wr_data = tgt_ent_q;
		if (!is_lookup) begin
			wr_data.font            = req_q.font_id;
			wr_data.code_point      = req_q.code_point;
			wr_data.desc.width      = req_q.glyph_width;
			wr_data.desc.height     = req_q.glyph_height;
			wr_data.desc.offset_x   = req_q.offset_x;
			wr_data.desc.offset_y   = req_q.offset_y;
			wr_data.desc.advance    = req_q.advance;
			wr_data.desc.bpp        = req_q.bits_per_pixel;
		end
		wr_data.age = age_nxt;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tgt_q] <= wr_data;
		end
		rd_data_q <= mem[scan_q[SW-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_q <= req;
		end
		if (state_q == ST_AREA) begin
			area_q <= glc_pkg::AREA_W'(req_q.glyph_width) *
			          glc_pkg::AREA_W'(req_q.glyph_height);
		end
		if (issue) begin
			eval_idx_s1 <= scan_q[SW-1:0];
		end
		if (state_q == ST_SCAN && eval_vld_s1) begin
			if (is_lookup ? cmp.hit : (cmp.empty || cmp.older)) begin
				tgt_q     <= eval_idx_s1;
				tgt_ent_q <= rd_data_q;
			end
			if (!is_lookup && cmp.older) begin
				best_age_q <= rd_data_q.age;
			end
		end
		// descriptor fields only on a lookup hit, else zero
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q.hit          <= found_q && is_lookup;
			rsp_q.stored       <= found_q && !is_lookup;
			rsp_q.slot_index   <= found_q ? 5'(tgt_q) : 5'd0;
			rsp_q.out_width    <= (found_q && is_lookup) ? tgt_ent_q.desc.width : '0;
			rsp_q.out_height   <= (found_q && is_lookup) ? tgt_ent_q.desc.height : '0;
			rsp_q.out_offset_x <= (found_q && is_lookup) ? tgt_ent_q.desc.offset_x : '0;
			rsp_q.out_offset_y <= (found_q && is_lookup) ? tgt_ent_q.desc.offset_y : '0;
			rsp_q.out_advance  <= (found_q && is_lookup) ? tgt_ent_q.desc.advance : '0;
			rsp_q.out_bpp      <= (found_q && is_lookup) ? tgt_ent_q.desc.bpp : '0;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			eval_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
			age_q       <= '0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// loading a new response wins over the old one leaving
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (issue) begin
				scan_q <= scan_q + (SW + 1)'(1);
			end
			eval_vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						scan_q  <= '0;
						found_q <= 1'b0;
						state_q <= (req.req_type == glc_pkg::REQ_LOOKUP) ? ST_SCAN : ST_AREA;
					end
				end
				ST_AREA: begin
					state_q <= ST_SIZE;
				end
				ST_SIZE: begin
					state_q <= (bits > glc_pkg::BITS_W'(glc_pkg::SIZE_LIMIT)) ? ST_DONE : ST_SCAN;
				end
				ST_SCAN: begin
					if (eval_vld_s1) begin
						if (is_lookup) begin
							if (cmp.hit) begin
								state_q <= ST_WRITE;
							end else if (last) begin
								state_q <= ST_DONE;
							end
						end else if (cmp.empty || last) begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					valid_q[tgt_q] <= 1'b1;
					age_q          <= age_nxt;
					found_q        <= 1'b1;
					state_q        <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
